@@ design/bba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, codes and controller/datapath interface types of the
// buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Default heap geometry
  localparam int MIN_ORDER_DEF = 5;
  localparam int TOP_ORDER_DEF = 16;

  // Order field width in the block header (holds orders up to 31)
  localparam int ORDER_W   = 5;
  localparam int ADDR_W    = 32;
  localparam int HDR_BYTES = 16;
  localparam int ALIGN_LSB = 7;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_IGNORED   = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_BLOCK  = 3'd3,
    ST_BAD_FREE  = 3'd4
  } status_e;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLR,
    OP_LOAD,
    OP_DECODE,
    OP_FIND,
    OP_A_RD,
    OP_SPLIT_A,
    OP_SPLIT_B,
    OP_A_FIN,
    OP_F_CHK,
    OP_M_TEST,
    OP_M_CHK,
    OP_UL_CHK,
    OP_M_UP,
    OP_PUSH,
    OP_LOAD_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;    // clearing sweep at last unit
    logic is_free;     // request is a free
    logic dec_fail;    // request rejected at decode
    logic find_fail;   // no free list at or above the needed order
    logic split_more;  // current list is above the target list
    logic mark_ok;     // freed unit carries an allocation mark
    logic merge_ok;    // block is below the top order
    logic bud_match;   // buddy is free at equal order
    logic cur_ok;      // list walk pointer is valid
    logic cur_hit;     // list walk reached the buddy
    logic out_free;    // output register can take a result
  } dp_sts_t;

endpackage
`default_nettype wire

@@ design/buddy_block_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over one heap of 2^TOP_ORDER bytes: allocate and free
// requests in, one address/status result out per request.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                          | tuser
//  s_axis   | in        | [31:0] request_size,           | [0] kind
//           |           | [63:32] free_address           |
//  m_axis   | out       | [31:0] result_address          | [2:0] status
//  cfg      | in        | cfg_wdata_i = heap_base        | -
//
// One request at a time. An allocate takes the lowest non-empty list at or
// above the target order and splits its block down to that order; a free
// checks the allocation mark, merges while the buddy is free at equal order
// and unlinks it from its list, then pushes the block. A decode reject goes
// straight to the result. After reset a clearing sweep runs over every unit
// of the header and link memories with s_axis_tready low. A stalled result holds
// in the output register; the sequencer waits on it before loading the next.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
  parameter int MIN_ORDER = bba_pkg::MIN_ORDER_DEF,
  parameter int TOP_ORDER = bba_pkg::TOP_ORDER_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,    // heap_base
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [31:0] request_size, [63:32] free_address
  input  wire logic        s_axis_tuser,   // [0] kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] result_address
  output logic [2:0]       m_axis_tuser    // [2:0] status
);

  bba_pkg::dp_cmd_t cmd;
  bba_pkg::dp_sts_t sts;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bba_datapath #(
    .MIN_ORDER (MIN_ORDER),
    .TOP_ORDER (TOP_ORDER)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_kind_i    (s_axis_tuser),
    .in_size_i    (s_axis_tdata[31:0]),
    .in_faddr_i   (s_axis_tdata[63:32]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_addr_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

  // One request in flight: ready drops after each accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  // Only a completed allocate carries an address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != 3'(bba_pkg::ST_DONE)) |-> (m_axis_tdata == 32'd0))
    else $error("failed request returned an address");

  // Status stays within the defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= 3'(bba_pkg::ST_BAD_FREE)))
    else $error("undefined status code");

endmodule
`default_nettype wire

@@ design/bba_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

@@ design/bba_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_datapath
// Free list heads, block header and link memories, request decode, address
// arithmetic and the output register of the buddy block allocator.
// ----------------------------------------------------------------------------
module bba_datapath #(
  parameter int MIN_ORDER = bba_pkg::MIN_ORDER_DEF,
  parameter int TOP_ORDER = bba_pkg::TOP_ORDER_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire bba_pkg::dp_cmd_t cmd_i,
  output bba_pkg::dp_sts_t      sts_o,
  input  wire logic             cfg_we_i,
  input  wire logic [31:0]      cfg_wdata_i,
  input  wire logic             in_kind_i,
  input  wire logic [31:0]      in_size_i,
  input  wire logic [31:0]      in_faddr_i,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output logic [31:0]           out_addr_o,
  output logic [2:0]            out_status_o
);

  localparam int UW     = TOP_ORDER - MIN_ORDER;
  localparam int NUNITS = 1 << UW;
  localparam int NO     = TOP_ORDER - MIN_ORDER + 1;
  localparam int LW     = (NO > 1) ? $clog2(NO) : 1;
  localparam int OW     = bba_pkg::ORDER_W;
  localparam int HW     = OW + 2;
  localparam int KW     = UW + 1;
  localparam int TW     = 34;

  // Request registers
  logic [31:0]      heap_base_q;
  logic             kind_q;
  logic [TW-1:0]    total_q;
  logic             size_zero_q;
  logic             addr_zero_q;
  logic [31:0]      off_q;

  // Walk registers
  logic [LW-1:0]    tl_q, ol_q;
  logic [UW-1:0]    u_q, bud_q, cur_q, prev_q;
  logic             have_prev_q, cur_ok_q;
  logic [UW-1:0]    clr_q;

  // Free list heads
  logic [UW-1:0]    heads_q [NO];
  logic [NO-1:0]    hv_q;

  // Result and output registers
  logic [31:0]      res_addr_q;
  bba_pkg::status_e res_st_q;
  logic             out_valid_q;
  logic [31:0]      out_addr_q;
  bba_pkg::status_e out_st_q;

  // Memory ports
  logic          hdr_we, lnk_we;
  logic [UW-1:0] hdr_waddr, hdr_raddr, lnk_waddr, lnk_raddr;
  logic [HW-1:0] hdr_wdata, hdr_rdata;
  logic [KW-1:0] lnk_wdata, lnk_rdata;

  // Combinational helpers
  logic [TW-1:0] total_c;
  logic [31:0]   off_c;
  logic [LW-1:0] ord_li_c, found_li_c, ol_dn_c, ol_up_c;
  logic          found_c, off_bad_c, too_large_c;
  logic [UW-1:0] off_unit_c, bit_c, bit_dn_c;
  logic          hdr_mark_c, hdr_free_c;
  logic [OW-1:0] hdr_ord_c;

  function automatic logic [HW-1:0] hdr_word(input logic mark, input logic free,
                                             input logic [LW-1:0] li);
    hdr_word = {mark, free, OW'(li) + OW'(MIN_ORDER)};
  endfunction

  assign total_c     = ((TW'(in_size_i) + TW'(bba_pkg::ALIGN_LSB)) & ~TW'(bba_pkg::ALIGN_LSB))
                       + TW'(bba_pkg::HDR_BYTES);
  assign off_c       = in_faddr_i - heap_base_q - 32'(bba_pkg::HDR_BYTES);
  assign off_bad_c   = ((off_q >> TOP_ORDER) != 32'd0) ||
                       ((off_q & ((32'd1 << MIN_ORDER) - 32'd1)) != 32'd0);
  assign too_large_c = total_q > (TW'(1) << TOP_ORDER);
  assign off_unit_c  = UW'(off_q >> MIN_ORDER);
  assign ol_dn_c     = ol_q - LW'(1);
  assign ol_up_c     = ol_q + LW'(1);
  assign bit_c       = UW'(1) << ol_q;
  assign bit_dn_c    = UW'(1) << ol_dn_c;
  assign hdr_mark_c  = hdr_rdata[HW-1];
  assign hdr_free_c  = hdr_rdata[HW-2];
  assign hdr_ord_c   = hdr_rdata[OW-1:0];

  // Smallest order whose block holds the request
  always_comb begin
    ord_li_c = LW'(NO - 1);
    for (int o = TOP_ORDER; o >= MIN_ORDER; o--) begin
      if (total_q <= (TW'(1) << o)) begin
        ord_li_c = LW'(o - MIN_ORDER);
      end
    end
  end

  // Lowest non-empty list at or above the target
  always_comb begin
    found_c    = 1'b0;
    found_li_c = '0;
    for (int i = NO - 1; i >= 0; i--) begin
      if (hv_q[i] && (LW'(i) >= tl_q)) begin
        found_c    = 1'b1;
        found_li_c = LW'(i);
      end
    end
  end

  // Memory address and write selection
  always_comb begin
    hdr_we    = 1'b0;
    hdr_waddr = u_q;
    hdr_wdata = hdr_word(1'b0, 1'b1, ol_q);
    hdr_raddr = off_unit_c;
    lnk_we    = 1'b0;
    lnk_waddr = u_q;
    lnk_wdata = {hv_q[ol_q], heads_q[ol_q]};
    lnk_raddr = cur_q;
    unique case (cmd_i.op)
      bba_pkg::OP_CLR: begin
        hdr_we    = 1'b1;
        hdr_waddr = clr_q;
        hdr_wdata = (clr_q == '0) ? hdr_word(1'b0, 1'b1, LW'(NO - 1)) : '0;
        lnk_we    = 1'b1;
        lnk_waddr = clr_q;
        lnk_wdata = '0;
      end
      bba_pkg::OP_A_RD: begin
        lnk_raddr = heads_q[ol_q];
      end
      bba_pkg::OP_SPLIT_A: begin
        hdr_we    = 1'b1;
        hdr_wdata = hdr_word(1'b0, 1'b1, ol_dn_c);
        lnk_we    = 1'b1;
        lnk_wdata = {hv_q[ol_dn_c], heads_q[ol_dn_c]};
      end
      bba_pkg::OP_SPLIT_B: begin
        hdr_we    = 1'b1;
        hdr_waddr = bud_q;
        lnk_we    = 1'b1;
        lnk_waddr = bud_q;
      end
      bba_pkg::OP_A_FIN: begin
        hdr_we    = 1'b1;
        hdr_wdata = hdr_word(1'b1, 1'b0, ol_q);
      end
      bba_pkg::OP_F_CHK: begin
        hdr_we    = hdr_mark_c;
        hdr_wdata = {1'b0, 1'b1, hdr_ord_c};
      end
      bba_pkg::OP_M_TEST: begin
        hdr_raddr = u_q ^ bit_c;
      end
      bba_pkg::OP_UL_CHK: begin
        lnk_we    = (cur_q == bud_q) && have_prev_q;
        lnk_waddr = prev_q;
        lnk_wdata = lnk_rdata;
      end
      bba_pkg::OP_M_UP: begin
        hdr_we    = 1'b1;
        hdr_waddr = u_q & ~bit_c;
        hdr_wdata = hdr_word(1'b0, 1'b1, ol_up_c);
      end
      bba_pkg::OP_PUSH: begin
        lnk_we    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Header memory: {allocation mark, free, order} per unit
  bba_ram #(.WIDTH(HW), .DEPTH(NUNITS)) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (hdr_we),
    .waddr_i (hdr_waddr),
    .wdata_i (hdr_wdata),
    .raddr_i (hdr_raddr),
    .rdata_o (hdr_rdata)
  );

  // Link memory: {next valid, next unit} per unit
  bba_ram #(.WIDTH(KW), .DEPTH(NUNITS)) u_lnk_ram (
    .clk_i   (clk_i),
    .we_i    (lnk_we),
    .waddr_i (lnk_waddr),
    .wdata_i (lnk_wdata),
    .raddr_i (lnk_raddr),
    .rdata_o (lnk_rdata)
  );

  // Control state: heap base, list heads, sweep counter, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
      hv_q        <= NO'(1) << (NO - 1);
      for (int i = 0; i < NO; i++) begin
        heads_q[i] <= '0;
      end
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        heap_base_q <= cfg_wdata_i;
      end
      if (cmd_i.op == bba_pkg::OP_LOAD_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        bba_pkg::OP_CLR: begin
          clr_q <= clr_q + UW'(1);
        end
        bba_pkg::OP_SPLIT_A: begin
          heads_q[ol_q]    <= lnk_rdata[UW-1:0];
          hv_q[ol_q]       <= lnk_rdata[KW-1];
          heads_q[ol_dn_c] <= u_q;
          hv_q[ol_dn_c]    <= 1'b1;
        end
        bba_pkg::OP_SPLIT_B: begin
          heads_q[ol_q] <= bud_q;
          hv_q[ol_q]    <= 1'b1;
        end
        bba_pkg::OP_A_FIN: begin
          heads_q[ol_q] <= lnk_rdata[UW-1:0];
          hv_q[ol_q]    <= lnk_rdata[KW-1];
        end
        bba_pkg::OP_UL_CHK: begin
          if ((cur_q == bud_q) && !have_prev_q) begin
            heads_q[ol_q] <= lnk_rdata[UW-1:0];
            hv_q[ol_q]    <= lnk_rdata[KW-1];
          end
        end
        bba_pkg::OP_PUSH: begin
          heads_q[ol_q] <= u_q;
          hv_q[ol_q]    <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Request and walk payload registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      bba_pkg::OP_LOAD: begin
        kind_q      <= in_kind_i;
        total_q     <= total_c;
        size_zero_q <= (in_size_i == 32'd0);
        addr_zero_q <= (in_faddr_i == 32'd0);
        off_q       <= off_c;
      end
      bba_pkg::OP_DECODE: begin
        res_addr_q <= '0;
        u_q        <= off_unit_c;
        tl_q       <= ord_li_c;
        if (kind_q == bba_pkg::KIND_FREE) begin
          if (addr_zero_q) begin
            res_st_q <= bba_pkg::ST_IGNORED;
          end else if (off_bad_c) begin
            res_st_q <= bba_pkg::ST_BAD_FREE;
          end else begin
            res_st_q <= bba_pkg::ST_DONE;
          end
        end else begin
          if (size_zero_q) begin
            res_st_q <= bba_pkg::ST_IGNORED;
          end else if (too_large_c) begin
            res_st_q <= bba_pkg::ST_TOO_LARGE;
          end else begin
            res_st_q <= bba_pkg::ST_DONE;
          end
        end
      end
      bba_pkg::OP_FIND: begin
        ol_q <= found_li_c;
        if (!found_c) begin
          res_st_q <= bba_pkg::ST_NO_BLOCK;
        end
      end
      bba_pkg::OP_A_RD: begin
        u_q <= heads_q[ol_q];
      end
      bba_pkg::OP_SPLIT_A: begin
        ol_q  <= ol_dn_c;
        bud_q <= u_q ^ bit_dn_c;
      end
      bba_pkg::OP_A_FIN: begin
        res_addr_q <= heap_base_q + (32'(u_q) << MIN_ORDER) + 32'(bba_pkg::HDR_BYTES);
      end
      bba_pkg::OP_F_CHK: begin
        if (hdr_mark_c) begin
          ol_q <= LW'(hdr_ord_c - OW'(MIN_ORDER));
        end else begin
          res_st_q <= bba_pkg::ST_BAD_FREE;
        end
      end
      bba_pkg::OP_M_TEST: begin
        bud_q <= u_q ^ bit_c;
      end
      bba_pkg::OP_M_CHK: begin
        cur_q       <= heads_q[ol_q];
        cur_ok_q    <= hv_q[ol_q];
        have_prev_q <= 1'b0;
      end
      bba_pkg::OP_UL_CHK: begin
        if (cur_q != bud_q) begin
          prev_q      <= cur_q;
          cur_q       <= lnk_rdata[UW-1:0];
          cur_ok_q    <= lnk_rdata[KW-1];
          have_prev_q <= 1'b1;
        end
      end
      bba_pkg::OP_M_UP: begin
        u_q  <= u_q & ~bit_c;
        ol_q <= ol_up_c;
      end
      bba_pkg::OP_LOAD_OUT: begin
        out_addr_q <= res_addr_q;
        out_st_q   <= res_st_q;
      end
      default: begin
      end
    endcase
  end

  // Status to the controller
  always_comb begin
    sts_o.clr_done   = &clr_q;
    sts_o.is_free    = (kind_q == bba_pkg::KIND_FREE);
    sts_o.dec_fail   = (kind_q == bba_pkg::KIND_FREE) ? (addr_zero_q || off_bad_c)
                                                      : (size_zero_q || too_large_c);
    sts_o.find_fail  = !found_c;
    sts_o.split_more = (ol_q != tl_q);
    sts_o.mark_ok    = hdr_mark_c;
    sts_o.merge_ok   = (ol_q != LW'(NO - 1));
    sts_o.bud_match  = hdr_free_c && (hdr_ord_c == (OW'(ol_q) + OW'(MIN_ORDER)));
    sts_o.cur_ok     = cur_ok_q;
    sts_o.cur_hit    = (cur_q == bud_q);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_addr_o   = out_addr_q;
  assign out_status_o = out_st_q;

endmodule
`default_nettype wire

@@ design/bba_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer of the buddy block allocator: clearing sweep, request decode,
// split loop, merge loop with free list walk, result hand-off.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire bba_pkg::dp_sts_t sts_i,
  output bba_pkg::dp_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_FIND,
    S_A_RD,
    S_SPLIT_A,
    S_SPLIT_B,
    S_A_FIN,
    S_F_CHK,
    S_M_TEST,
    S_M_CHK,
    S_UL_RD,
    S_UL_CHK,
    S_M_UP,
    S_PUSH,
    S_FINISH
  } state_e;

  state_e state_q;

  // Operation per state
  always_comb begin
    unique case (state_q)
      S_CLEAR:   cmd_o.op = bba_pkg::OP_CLR;
      S_IDLE:    cmd_o.op = in_valid_i ? bba_pkg::OP_LOAD : bba_pkg::OP_NOP;
      S_DECODE:  cmd_o.op = bba_pkg::OP_DECODE;
      S_FIND:    cmd_o.op = bba_pkg::OP_FIND;
      S_A_RD:    cmd_o.op = bba_pkg::OP_A_RD;
      S_SPLIT_A: cmd_o.op = bba_pkg::OP_SPLIT_A;
      S_SPLIT_B: cmd_o.op = bba_pkg::OP_SPLIT_B;
      S_A_FIN:   cmd_o.op = bba_pkg::OP_A_FIN;
      S_F_CHK:   cmd_o.op = bba_pkg::OP_F_CHK;
      S_M_TEST:  cmd_o.op = bba_pkg::OP_M_TEST;
      S_M_CHK:   cmd_o.op = bba_pkg::OP_M_CHK;
      S_UL_RD:   cmd_o.op = bba_pkg::OP_NOP;
      S_UL_CHK:  cmd_o.op = bba_pkg::OP_UL_CHK;
      S_M_UP:    cmd_o.op = bba_pkg::OP_M_UP;
      S_PUSH:    cmd_o.op = bba_pkg::OP_PUSH;
      S_FINISH:  cmd_o.op = sts_i.out_free ? bba_pkg::OP_LOAD_OUT : bba_pkg::OP_NOP;
      default:   cmd_o.op = bba_pkg::OP_NOP;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      unique case (state_q)
        S_CLEAR:   if (sts_i.clr_done) state_q <= S_IDLE;
        S_IDLE:    if (in_valid_i) state_q <= S_DECODE;
        S_DECODE: begin
          if (sts_i.dec_fail) begin
            state_q <= S_FINISH;
          end else if (sts_i.is_free) begin
            state_q <= S_F_CHK;
          end else begin
            state_q <= S_FIND;
          end
        end
        S_FIND:    state_q <= sts_i.find_fail ? S_FINISH : S_A_RD;
        S_A_RD:    state_q <= sts_i.split_more ? S_SPLIT_A : S_A_FIN;
        S_SPLIT_A: state_q <= S_SPLIT_B;
        S_SPLIT_B: state_q <= S_A_RD;
        S_A_FIN:   state_q <= S_FINISH;
        S_F_CHK:   state_q <= sts_i.mark_ok ? S_M_TEST : S_FINISH;
        S_M_TEST:  state_q <= sts_i.merge_ok ? S_M_CHK : S_PUSH;
        S_M_CHK:   state_q <= sts_i.bud_match ? S_UL_RD : S_PUSH;
        // a buddy missing from its list still merges
        S_UL_RD:   state_q <= sts_i.cur_ok ? S_UL_CHK : S_M_UP;
        S_UL_CHK:  state_q <= sts_i.cur_hit ? S_M_UP : S_UL_RD;
        S_M_UP:    state_q <= S_M_TEST;
        S_PUSH:    state_q <= S_FINISH;
        S_FINISH:  if (sts_i.out_free) state_q <= S_IDLE;
        default:   state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
